// ===== hw/rtl/i2a_pkg.sv =====
// Shared types, character codes and sizing helpers for the integer to ASCII formatter.
package i2a_pkg;

  // Operation codes carried on the input stream; code 3 has no meaning.
  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEX  = 2'd2
  } i2a_op_e;

  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharA     = 8'h61;  // 'a'
  localparam logic [7:0] CharMinus = 8'h2d;  // '-'
  localparam logic [3:0] NibTen    = 4'd10;

  // Start command from the sequencer to the conversion unit.
  typedef struct packed {
    logic load;  // take a new magnitude
    logic hex;   // nibbles are the digits, no iteration
  } i2a_ctrl_t;

  // Decimal digits needed for a w-bit unsigned value: floor(w*log10(2)) + 1.
  function automatic int i2a_num_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

endpackage

// ===== hw/rtl/i2a_bcd_unit.sv =====
// Shift-add-3 binary to BCD unit, one bit per cycle; loads nibbles directly for hex.
module i2a_bcd_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int NUM_DIG     = 10,
  parameter int IDX_W       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2a_pkg::i2a_ctrl_t     ctrl_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  output logic                   done_o,
  output logic [NUM_DIG*4-1:0]   digits_o,
  output logic [IDX_W-1:0]       msd_o
);

  localparam int CntW = $clog2(VALUE_WIDTH + 1);
  localparam int BcdW = NUM_DIG * 4;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [BcdW-1:0]        adj;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   run_q, run_d;
  logic                   done_q, done_d;

  // add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (ctrl_i.load) begin
      if (ctrl_i.hex) begin
        bcd_d  = BcdW'(mag_i);
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        bin_d = mag_i;
        bcd_d = '0;
        cnt_d = CntW'(VALUE_WIDTH);
        run_d = 1'b1;
      end
    end else if (run_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // most significant nonzero digit, digit 0 when the value is zero
  always_comb begin
    msd_o = '0;
    for (int i = 0; i < NUM_DIG; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        msd_o = IDX_W'(i);
      end
    end
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: stream ports, sequencer and output register.
//
// Each input transfer carries a value and a mode (signed decimal, unsigned
// decimal, lowercase hex); the block answers with the ASCII characters of
// the number, most significant first, no leading zeros, tlast on the final
// one. Zero prints as "0"; a negative signed value gets a leading '-' and its
// magnitude is formed in VALUE_WIDTH bits, so the most negative value prints
// exactly. Value bits above VALUE_WIDTH are ignored; mode 3 is accepted and
// gives no output. Decimal modes pass the magnitude through the shift-add-3
// BCD unit (one bit per cycle), hex loads the nibbles directly; then one
// character leaves per cycle through the output register while the
// downstream side is ready. With the default width a decimal value has at
// most 11 characters. The input is ready only while the sequencer is idle,
// which includes while the last character still waits in the output
// register.
module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] value, [33:32] operation, [39:34] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] character
  output logic        m_axis_tlast_o
);

  localparam int NumDig = i2a_pkg::i2a_num_digits(VALUE_WIDTH);
  localparam int IdxW   = $clog2(NumDig);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_e;

  state_e                 state_q;
  logic                   sign_q;
  logic [IdxW-1:0]        idx_q;
  logic                   m_valid_q;
  logic [7:0]             m_data_q;
  logic                   m_last_q;

  i2a_pkg::i2a_op_e       op;
  i2a_pkg::i2a_ctrl_t     ctrl;
  logic                   in_xfer;
  logic                   op_ok;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] val_w;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   unit_done;
  logic [NumDig*4-1:0]    digits;
  logic [IdxW-1:0]        msd;
  logic [3:0]             dig;
  logic [7:0]             dig_char;
  logic                   out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign op    = i2a_pkg::i2a_op_e'(s_axis_tdata_i[33:32]);
  assign op_ok = (op == i2a_pkg::OP_SDEC) || (op == i2a_pkg::OP_UDEC) ||
                 (op == i2a_pkg::OP_HEX);
  assign val_w = VALUE_WIDTH'(s_axis_tdata_i[31:0]);
  assign neg   = (op == i2a_pkg::OP_SDEC) && val_w[VALUE_WIDTH-1];
  // two's complement magnitude wraps in VALUE_WIDTH bits, so the most
  // negative value comes out as its unsigned magnitude
  assign mag   = neg ? (~val_w + VALUE_WIDTH'(1)) : val_w;

  assign ctrl.load = in_xfer && op_ok;
  assign ctrl.hex  = (op == i2a_pkg::OP_HEX);

  i2a_bcd_unit #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIG     (NumDig),
    .IDX_W       (IdxW)
  ) u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .mag_i    (mag),
    .done_o   (unit_done),
    .digits_o (digits),
    .msd_o    (msd)
  );

  // digit to ASCII: decimal digits never reach ten
  assign dig      = digits[idx_q*4 +: 4];
  assign dig_char = (dig < i2a_pkg::NibTen) ? (i2a_pkg::CharZero + 8'(dig))
                                            : (i2a_pkg::CharA + 8'(dig - i2a_pkg::NibTen));

  // output register can take a character when empty or being drained
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sign_q    <= 1'b0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      // while emitting, the refill below decides the valid bit
      if (m_axis_tready_i && (state_q != S_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer && op_ok) begin
            sign_q  <= neg;
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          if (unit_done) begin
            idx_q   <= msd;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            if (sign_q) begin
              m_data_q <= i2a_pkg::CharMinus;
              m_last_q <= 1'b0;
              sign_q   <= 1'b0;
            end else begin
              m_data_q <= dig_char;
              m_last_q <= (idx_q == '0);
              if (idx_q == '0) begin
                state_q <= S_IDLE;
              end else begin
                idx_q <= idx_q - IdxW'(1);
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
